// ===== sv/fdx_pkg.sv =====
`timescale 1ns / 1ps

package fdx_pkg;

  // Payload store geometry: two banks of one frame each.
  localparam int PAYLOAD_DEPTH = 64;
  localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);
  localparam int ADDR_W        = IDX_W + 1;
  localparam int STORE_DEPTH   = 1 << ADDR_W;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_COMMAND_CODE  = 2'd2;

  // Result kinds and error codes.
  localparam logic       KIND_FRAME = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CMD    = 2'd1;
  localparam logic [1:0] ERR_LEN    = 2'd2;
  localparam logic [1:0] ERR_SUM    = 2'd3;

  localparam logic [5:0] MIN_BODY_LEN = 6'd2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // One result item apart from its payload byte, which comes from the store.
  typedef struct packed {
    logic       kind;
    logic [1:0] code;
    logic [1:0] count;
    logic [5:0] blen;
    logic [7:0] sexp;
    logic [7:0] srcv;
    logic       pvalid;
    logic [5:0] pidx;
    logic       last;
  } res_t;

endpackage

// ===== sv/fdx_ram.sv =====
`timescale 1ns / 1ps

module fdx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/frame_deframer_xor_checksum.sv =====
`timescale 1ns / 1ps

// Frame deframer with a two-byte header and an XOR checksum.
// Received bytes enter on the input channel (in_valid, in_stall, rx_byte), one item
// per cycle unless stalled. The parser hunts for header_first then header_second,
// checks the command byte, takes the length byte and writes the payload into a
// two-bank RAM, folding the length byte and every payload byte into a running XOR.
// Results leave on the output channel (out_valid, out_stall and the result fields).
// A good frame gives one item per payload byte, the last one marked, or a single
// item when the payload is empty; each fault gives a single error item.
// Results pass through the drain job, read stage and output register. Throughput:
// one input byte per cycle unless stalled. A frame's payload drains at one item per
// cycle, unless the receiver stalls, from the RAM read port while the next frame
// fills the other bank; the input stalls only on a byte that would start a new
// result run before the previous run is fully issued to the output side.
// Reset (rst, synchronous) returns the parser to hunting, clears the
// configuration registers and empties the output side; the RAM is not cleared.
// When the receiver stalls, the output register and the read stage behind it
// hold, the RAM read port stops and the input backs up once a run is waiting.
// Configuration registers are written through cfg_write, cfg_index and cfg_data.

module frame_deframer_xor_checksum (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [1:0] error_code,
  output logic [1:0] frame_count,
  output logic [5:0] body_len,
  output logic [7:0] sum_expected,
  output logic [7:0] sum_received,
  output logic [7:0] payload_byte,
  output logic       payload_valid,
  output logic [5:0] payload_index,
  output logic       last
);

  import fdx_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_CMD,
    PH_LEN,
    PH_PAYLOAD,
    PH_SUM
  } phase_t;

  // Configuration registers.
  logic [7:0] header_first;
  logic [7:0] header_second;
  logic [7:0] command_code;

  // Parser state.
  phase_t     phase;
  logic [5:0] pos;
  logic [5:0] held_len;
  logic [1:0] held_cnt;
  logic [7:0] run_xor;
  logic       wbank;

  // Drain job: the result run currently being issued.
  logic       job_active;
  res_t       job_res;
  logic [5:0] job_idx;
  logic [5:0] job_last_idx;
  logic       job_bank;

  // Read stage (RAM data arrives with it) and output register.
  logic       s1_valid;
  res_t       s1_res;
  res_t       out_res;
  logic [7:0] out_byte;

  logic       want_res;
  res_t       new_res;
  logic [5:0] new_last_idx;
  res_t       issue_res;
  logic       in_fire;
  logic       launch;
  logic       out_free;
  logic       issue;
  logic       issue_last;
  logic       job_free;
  logic [5:0] pos_inc;
  logic       store_we;
  addr_t      store_waddr;
  addr_t      store_raddr;
  logic       store_re;
  logic [7:0] store_rdata;

  // Decide whether the byte on the input would emit a result, and with what fields.
  always_comb begin
    want_res     = 1'b0;
    new_res      = '0;
    new_res.last = 1'b1;
    new_last_idx = '0;
    case (phase)
      PH_CMD: begin
        if (rx_byte != command_code) begin
          want_res     = 1'b1;
          new_res.kind = KIND_ERROR;
          new_res.code = ERR_CMD;
        end
      end
      PH_LEN: begin
        if (rx_byte[5:0] < MIN_BODY_LEN) begin
          want_res      = 1'b1;
          new_res.kind  = KIND_ERROR;
          new_res.code  = ERR_LEN;
          new_res.count = rx_byte[7:6];
          new_res.blen  = rx_byte[5:0];
        end
      end
      PH_SUM: begin
        want_res      = 1'b1;
        new_res.count = held_cnt;
        new_res.blen  = held_len;
        new_res.sexp  = run_xor;
        new_res.srcv  = rx_byte;
        if (run_xor != rx_byte) begin
          new_res.kind = KIND_ERROR;
          new_res.code = ERR_SUM;
        end else if (held_len == MIN_BODY_LEN) begin
          new_res.kind = KIND_FRAME;
          new_res.code = ERR_NONE;
        end else begin
          new_res.kind   = KIND_FRAME;
          new_res.code   = ERR_NONE;
          new_res.pvalid = 1'b1;
          new_last_idx   = held_len - 6'd3;
        end
      end
      default: begin
        want_res = 1'b0;
      end
    endcase
  end

  // The item that the drain job hands to the read stage this cycle.
  always_comb begin
    issue_res      = job_res;
    issue_res.pidx = job_res.pvalid ? job_idx : 6'd0;
    issue_res.last = issue_last;
  end

  assign out_free   = !out_valid || !out_stall;
  assign issue      = job_active && (!s1_valid || out_free);
  assign issue_last = job_idx == job_last_idx;
  assign job_free   = !job_active || (issue && issue_last);
  assign in_stall   = want_res && !job_free;
  assign in_fire    = in_valid && !in_stall;
  assign launch     = in_fire && want_res;
  assign pos_inc    = pos + 6'd1;

  // Payload store: the parser writes its bank, the drain side reads the other one.
  assign store_we    = in_fire && (phase == PH_PAYLOAD);
  assign store_waddr = {wbank, idx_t'(pos)};
  assign store_re    = issue && job_res.pvalid;
  assign store_raddr = {job_bank, idx_t'(job_idx)};

  fdx_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (rx_byte),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= '0;
      header_second <= '0;
      command_code  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        REG_COMMAND_CODE:  command_code  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Parser.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT0;
      pos      <= '0;
      held_len <= '0;
      held_cnt <= '0;
      run_xor  <= '0;
      wbank    <= 1'b0;
    end else if (in_fire) begin
      case (phase)
        PH_HUNT1: begin
          if (rx_byte == header_second) begin
            phase <= PH_CMD;
          end else if (rx_byte != header_first) begin
            phase <= PH_HUNT0;
          end
        end
        PH_CMD: begin
          phase <= (rx_byte == command_code) ? PH_LEN : PH_HUNT0;
        end
        PH_LEN: begin
          held_len <= rx_byte[5:0];
          held_cnt <= rx_byte[7:6];
          if (rx_byte[5:0] < MIN_BODY_LEN) begin
            phase <= PH_HUNT0;
          end else begin
            run_xor <= rx_byte;
            pos     <= '0;
            phase   <= (rx_byte[5:0] == MIN_BODY_LEN) ? PH_SUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          run_xor <= run_xor ^ rx_byte;
          pos     <= pos_inc;
          if (pos_inc >= held_len - MIN_BODY_LEN) begin
            phase <= PH_SUM;
          end
        end
        PH_SUM: begin
          phase <= PH_HUNT0;
          if (launch && new_res.pvalid) begin
            wbank <= !wbank;
          end
        end
        default: begin
          phase <= (rx_byte == header_first) ? PH_HUNT1 : PH_HUNT0;
        end
      endcase
    end
  end

  // Drain job, read stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_active <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (launch) begin
        job_active   <= 1'b1;
        job_res      <= new_res;
        job_idx      <= '0;
        job_last_idx <= new_last_idx;
        job_bank     <= wbank;
      end else if (issue) begin
        if (issue_last) begin
          job_active <= 1'b0;
        end else begin
          job_idx <= job_idx + 6'd1;
        end
      end

      if (issue) begin
        s1_res <= issue_res;
      end
      s1_valid <= issue || (s1_valid && !out_free);

      if (out_free) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          out_res  <= s1_res;
          out_byte <= s1_res.pvalid ? store_rdata : 8'd0;
        end
      end
    end
  end

  assign result_kind   = out_res.kind;
  assign error_code    = out_res.code;
  assign frame_count   = out_res.count;
  assign body_len      = out_res.blen;
  assign sum_expected  = out_res.sexp;
  assign sum_received  = out_res.srcv;
  assign payload_byte  = out_byte;
  assign payload_valid = out_res.pvalid;
  assign payload_index = out_res.pidx;
  assign last          = out_res.last;

`ifndef SYNTHESIS
  // The parser never writes the bank that a payload run is still reading.
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (store_we && job_active && job_res.pvalid) |-> (job_bank != wbank))
    else $error("payload write hits the bank being drained");

  // The read stage holds its item while the output register is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_res)))
    else $error("read stage changed while blocked");

  // A run index never passes the last index of its run.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    job_active |-> (job_idx <= job_last_idx))
    else $error("drain index beyond run length");

  // Items without payload data always close their run.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !payload_valid) |-> last)
    else $error("result without payload is not marked last");
`endif

endmodule
